### rtl/wavp_pkg.sv
// wavp_pkg: types and constants shared by the wav chunk parser modules
// no dependencies
`timescale 1ns / 1ps

package wavp_pkg;

    // fnv-1a 64 constants
    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_MULT   = 64'h0000_0100_0000_01B3;

    // four character codes, first byte most significant
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // result status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_HDR   = 3'd1;
    localparam logic [2:0] STATUS_SHORT_FMT = 3'd2;
    localparam logic [2:0] STATUS_MISSING   = 3'd3;
    localparam logic [2:0] STATUS_TRUNC     = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] payload_hash;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [15:0] channel_count;
        logic [31:0] payload_length;
    } t_result;

endpackage

### rtl/wavp_ifs.sv
// wavp_in_if / wavp_out_if: valid-ready stream interfaces of the wav parser
// no dependencies
`timescale 1ns / 1ps

interface wavp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface wavp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] payload_hash;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [15:0] channel_count;
    logic [31:0] payload_length;

    modport source (output valid, output status, output payload_hash, output sample_rate,
                    output bits_per_sample, output channel_count, output payload_length,
                    input ready);
    modport sink   (input valid, input status, input payload_hash, input sample_rate,
                    input bits_per_sample, input channel_count, input payload_length,
                    output ready);
endinterface

### rtl/wavp_fnv_step.sv
// wavp_fnv_step: one fnv-1a 64 round, xor then multiply by the fnv prime
// no dependencies
`timescale 1ns / 1ps

module wavp_fnv_step (
    input  logic [63:0] i_hash,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_hash
);

    logic [63:0] w_x;

    // prime 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
    assign w_x    = i_hash ^ {56'd0, i_byte};
    assign o_hash = w_x + (w_x << 40) + (w_x << 8) + (w_x << 7) + (w_x << 5)
                  + (w_x << 4) + (w_x << 1);

endmodule

### rtl/wavp_parser.sv
// wavp_parser: riff/wave chunk walker state and next-state logic
// depends on wavp_pkg and wavp_fnv_step
`timescale 1ns / 1ps

module wavp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  wavp_pkg::t_item  i_item,
    output wavp_pkg::t_result o_result
);

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_CHDR    = 8'b0000_0010,
        PH_FMT     = 8'b0000_0100,
        PH_SKIP    = 8'b0000_1000,
        PH_DATA    = 8'b0001_0000,
        PH_PAD     = 8'b0010_0000,
        PH_REJ_HDR = 8'b0100_0000,
        PH_REJ_FMT = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_size, n_size;
    logic [63:0] r_hash, n_hash;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_data_size, n_data_size;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_data_seen, n_data_seen;
    logic        r_data_done, n_data_done;

    logic [63:0] w_hash_step;
    logic [31:0] w_tag_shift;
    logic [31:0] w_rest;
    logic [7:0]  w_b;
    logic [2:0]  w_status;

    assign w_b         = i_item.data_byte;
    assign w_tag_shift = {r_tag[23:0], w_b};
    assign w_rest      = r_size - 32'd16;

    wavp_fnv_step u_fnv (
        .i_hash (r_hash),
        .i_byte (w_b),
        .o_hash (w_hash_step)
    );

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_tag       = r_tag;
        n_size      = r_size;
        n_hash      = r_hash;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_data_size = r_data_size;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_data_done = r_data_done;

        unique case (r_phase) inside
            PH_HEADER: begin
                n_tag = w_tag_shift;
                if (r_count == 32'd3 && w_tag_shift != wavp_pkg::TAG_RIFF) begin
                    n_phase = PH_REJ_HDR;
                end else if (r_count == 32'd11) begin
                    n_phase = (w_tag_shift == wavp_pkg::TAG_WAVE) ? PH_CHDR : PH_REJ_HDR;
                    n_count = '0;
                end else begin
                    n_count = r_count + 32'd1;
                end
            end
            PH_CHDR: begin
                if (r_count < 32'd4) begin
                    n_tag = w_tag_shift;
                    if (r_count == 32'd0) begin
                        n_size = '0;
                    end
                end else begin
                    n_size = r_size | ({24'd0, w_b} << {r_count[1:0], 3'b000});
                end
                if (r_count < 32'd7) begin
                    n_count = r_count + 32'd1;
                end else if (n_tag == wavp_pkg::TAG_FMT) begin
                    if (n_size < 32'd16) begin
                        n_phase = PH_REJ_FMT;
                    end else begin
                        n_phase = PH_FMT;
                        n_count = '0;
                    end
                end else if (n_tag == wavp_pkg::TAG_DATA) begin
                    n_data_size = n_size;
                    n_hash      = wavp_pkg::FNV_OFFSET;
                    n_data_seen = 1'b1;
                    if (n_size == 32'd0) begin
                        n_data_done = 1'b1;
                        n_phase     = PH_CHDR;
                        n_count     = '0;
                    end else begin
                        n_data_done = 1'b0;
                        n_phase     = PH_DATA;
                        n_count     = n_size;
                    end
                end else if (n_size == 32'd0) begin
                    n_phase = PH_CHDR;
                    n_count = '0;
                end else begin
                    n_phase = PH_SKIP;
                    n_count = n_size;
                end
            end
            PH_FMT: begin
                // count stays below 16 in this phase
                case (r_count[3:0])
                    4'd2:    n_channels[7:0]  = w_b;
                    4'd3:    n_channels[15:8] = w_b;
                    4'd4:    n_rate[7:0]      = w_b;
                    4'd5:    n_rate[15:8]     = w_b;
                    4'd6:    n_rate[23:16]    = w_b;
                    4'd7:    n_rate[31:24]    = w_b;
                    4'd14:   n_bits[7:0]      = w_b;
                    4'd15:   n_bits[15:8]     = w_b;
                    default: ;
                endcase
                if (r_count[3:0] == 4'd15) begin
                    n_fmt_seen = 1'b1;
                    if (w_rest == 32'd0) begin
                        n_phase = r_size[0] ? PH_PAD : PH_CHDR;
                        n_count = '0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_count = w_rest;
                    end
                end else begin
                    n_count = r_count + 32'd1;
                end
            end
            PH_SKIP: begin
                n_count = r_count - 32'd1;
                if (r_count == 32'd1) begin
                    n_phase = r_size[0] ? PH_PAD : PH_CHDR;
                    n_count = '0;
                end
            end
            PH_DATA: begin
                n_hash  = w_hash_step;
                n_count = r_count - 32'd1;
                if (r_count == 32'd1) begin
                    n_data_done = 1'b1;
                    n_phase     = r_size[0] ? PH_PAD : PH_CHDR;
                    n_count     = '0;
                end
            end
            PH_PAD: begin
                n_phase = PH_CHDR;
                n_count = '0;
            end
            PH_REJ_HDR, PH_REJ_FMT: ;
            default: ;
        endcase
    end

    // status as seen after this byte
    always_comb begin
        if (n_phase == PH_HEADER || n_phase == PH_REJ_HDR) begin
            w_status = wavp_pkg::STATUS_BAD_HDR;
        end else if (n_phase == PH_FMT || n_phase == PH_REJ_FMT) begin
            w_status = wavp_pkg::STATUS_SHORT_FMT;
        end else if (!(n_fmt_seen && n_data_seen)) begin
            w_status = wavp_pkg::STATUS_MISSING;
        end else if (!n_data_done) begin
            w_status = wavp_pkg::STATUS_TRUNC;
        end else begin
            w_status = wavp_pkg::STATUS_OK;
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = w_status;
        if (w_status == wavp_pkg::STATUS_OK) begin
            o_result.payload_hash    = n_hash;
            o_result.sample_rate     = n_rate;
            o_result.bits_per_sample = n_bits;
            o_result.channel_count   = n_channels;
            o_result.payload_length  = n_data_size;
        end
    end

    // the final byte of a file returns everything to the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.end_of_file)) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_tag       <= '0;
            r_size      <= '0;
            r_hash      <= wavp_pkg::FNV_OFFSET;
            r_channels  <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_data_size <= '0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
            r_data_done <= 1'b0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_tag       <= n_tag;
            r_size      <= n_size;
            r_hash      <= n_hash;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_data_size <= n_data_size;
            r_fmt_seen  <= n_fmt_seen;
            r_data_seen <= n_data_seen;
            r_data_done <= n_data_done;
        end
    end

endmodule

### rtl/wav_chunk_parse_payload_hash.sv
// wav_chunk_parse_payload_hash: riff/wave parser with fnv-1a 64 payload hash
// depends on wavp_pkg, wavp_ifs (wavp_in_if, wavp_out_if) and wavp_parser
`timescale 1ns / 1ps

// channel   dir  fields                                         per transaction
// i_in      in   data_byte, end_of_file                         one file byte
// o_out     out  status, payload_hash, sample_rate,             one result per file
//                bits_per_sample, channel_count, payload_length
//
// one byte per cycle sustained while no final byte is held; a byte sits in the input register,
// then the parser updates its state and, on the final byte, loads the result register
// the final byte reaches its result through the input register and then the result register
// reset is synchronous and active low; it empties both registers and the parser
// a non-final byte never waits; the final byte holds in the input register while
// an earlier result is still not taken, and i_in.ready drops only then

module wav_chunk_parse_payload_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wavp_in_if.sink     i_in,
    wavp_out_if.source  o_out
);

    // input register
    logic              r_in_valid;
    wavp_pkg::t_item   r_item;

    // result register
    logic              r_out_valid;
    wavp_pkg::t_result r_out;

    wavp_pkg::t_result w_result;
    logic              w_out_free;
    logic              w_process;
    logic              w_fire_eof;
    logic              w_in_take;

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    // only the final byte needs room in the result register
    assign w_process  = r_in_valid && (!r_item.end_of_file || w_out_free);
    assign w_fire_eof = w_process && r_item.end_of_file;
    assign i_in.ready = !r_in_valid || w_process;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.end_of_file <= i_in.end_of_file;
        end
    end

    wavp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_process),
        .i_item   (r_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire_eof) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_eof) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.payload_hash    = r_out.payload_hash;
    assign o_out.sample_rate     = r_out.sample_rate;
    assign o_out.bits_per_sample = r_out.bits_per_sample;
    assign o_out.channel_count   = r_out.channel_count;
    assign o_out.payload_length  = r_out.payload_length;

    // a new result only follows a final byte processed in the cycle before
    a_result_from_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire_eof))
        else $error("result appeared without a final byte");

    // rejected files carry zero fields
    a_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != wavp_pkg::STATUS_OK) |->
        (r_out.payload_hash == 64'd0 && r_out.sample_rate == 32'd0 &&
         r_out.bits_per_sample == 16'd0 && r_out.channel_count == 16'd0 &&
         r_out.payload_length == 32'd0))
        else $error("nonzero field with failing status");

    // a byte waiting in the input register is never overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_process) |=> (r_in_valid && $stable(r_item)))
        else $error("input register lost a stalled byte");

endmodule

### dv/wav_chunk_parse_payload_hash_tb.sv
// wav_chunk_parse_payload_hash_tb: self-checking testbench of the riff/wave parser with payload hash
// depends on wavp_pkg, wavp_ifs (wavp_in_if, wavp_out_if) and wav_chunk_parse_payload_hash
`timescale 1ns / 1ps

module wav_chunk_parse_payload_hash_tb;

    // tags used for chunks the parser only skips
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_JUNK = 32'h6A75_6E6B;

    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 10;    // settle time after the last result
    localparam int RANDOM_FILES   = 4;
    localparam int QUIET_FILES    = 2;     // trailing random files with no idling

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_FMT_BODY,
        PH_SKIP,
        PH_PAYLOAD,
        PH_PAD,
        PH_BAD_HDR,
        PH_BAD_FMT
    } t_parse_phase;

    logic i_clk;
    logic i_rst_n;

    wavp_in_if  in_if ();
    wavp_out_if out_if ();

    wav_chunk_parse_payload_hash u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // predictor state, a private copy of the parser
    // ------------------------------------------------------------------
    t_parse_phase wav_phase;
    logic [31:0]  wav_count;      // position in header, chunk header or fmt body, or bytes left
    logic [31:0]  wav_tag;        // last four tag bytes, first byte on top
    logic [31:0]  wav_size;       // declared size of the current chunk
    logic [63:0]  wav_hash;       // running payload hash
    logic [15:0]  fmt_channels;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_bits;
    logic [31:0]  data_length;    // declared size of the last data chunk
    logic         fmt_captured;   // a full 16-byte fmt body was seen
    logic         data_opened;    // a data chunk header was seen
    logic         data_complete;  // the last data payload was hashed to its end

    wavp_pkg::t_result file_result_q[$];  // expected status results, oldest first
    logic [7:0]        file_bytes[$];     // file under construction

    int           mismatch_count;
    int           bytes_sent;
    int           stall_cycles;

    // stimulus controls shared between processes
    logic         src_idle_en;
    logic         snk_idle_en;
    logic         hold_req;
    logic         hold_busy;

    function automatic void wav_state_clear();
        wav_phase     = PH_HEADER;
        wav_count     = '0;
        wav_tag       = '0;
        wav_size      = '0;
        wav_hash      = wavp_pkg::FNV_OFFSET;
        fmt_channels  = '0;
        fmt_rate      = '0;
        fmt_bits      = '0;
        data_length   = '0;
        fmt_captured  = 1'b0;
        data_opened   = 1'b0;
        data_complete = 1'b0;
    endfunction

    // end of a chunk body: an odd size leaves one pad byte to swallow
    function automatic void body_finished();
        wav_phase = wav_size[0] ? PH_PAD : PH_CHUNK_HDR;
        wav_count = '0;
    endfunction

    function automatic void skip_or_finish(input logic [31:0] remaining);
        if (remaining == 0) begin
            body_finished();
        end else begin
            wav_phase = PH_SKIP;
            wav_count = remaining;
        end
    endfunction

    // advance the predictor by one accepted byte; a final byte yields a status result
    function automatic void wav_parse_step(input logic [7:0] value, input logic is_final);
        wavp_pkg::t_result res;
        case (wav_phase)
            PH_HEADER: begin
                wav_tag = {wav_tag[23:0], value};
                if (wav_count == 3 && wav_tag != wavp_pkg::TAG_RIFF) begin
                    wav_phase = PH_BAD_HDR;
                end else if (wav_count == 11) begin
                    wav_phase = (wav_tag == wavp_pkg::TAG_WAVE) ? PH_CHUNK_HDR : PH_BAD_HDR;
                    wav_count = '0;
                end else begin
                    wav_count++;
                end
            end
            PH_CHUNK_HDR: begin
                if (wav_count < 4) begin
                    wav_tag = {wav_tag[23:0], value};
                    if (wav_count == 0) wav_size = '0;
                end else begin
                    wav_size[8*(wav_count-4) +: 8] = value;
                end
                if (wav_count < 7) begin
                    wav_count++;
                end else if (wav_tag == wavp_pkg::TAG_FMT) begin
                    if (wav_size < 16) begin
                        wav_phase = PH_BAD_FMT;
                    end else begin
                        wav_phase = PH_FMT_BODY;
                        wav_count = '0;
                    end
                end else if (wav_tag == wavp_pkg::TAG_DATA) begin
                    data_length   = wav_size;
                    wav_hash      = wavp_pkg::FNV_OFFSET;
                    data_opened   = 1'b1;
                    data_complete = 1'b0;
                    if (wav_size == 0) begin
                        data_complete = 1'b1;
                        body_finished();
                    end else begin
                        wav_phase = PH_PAYLOAD;
                        wav_count = wav_size;
                    end
                end else begin
                    skip_or_finish(wav_size);
                end
            end
            PH_FMT_BODY: begin
                // channels at body bytes 2..3, rate at 4..7, bits at 14..15
                if (wav_count == 2 || wav_count == 3)
                    fmt_channels[8*(wav_count-2) +: 8] = value;
                else if (wav_count >= 4 && wav_count <= 7)
                    fmt_rate[8*(wav_count-4) +: 8] = value;
                else if (wav_count >= 14)
                    fmt_bits[8*(wav_count-14) +: 8] = value;
                if (wav_count == 15) begin
                    fmt_captured = 1'b1;
                    skip_or_finish(wav_size - 32'd16);
                end else begin
                    wav_count++;
                end
            end
            PH_SKIP: begin
                wav_count--;
                if (wav_count == 0) body_finished();
            end
            PH_PAYLOAD: begin
                wav_hash = (wav_hash ^ 64'(value)) * wavp_pkg::FNV_MULT;
                wav_count--;
                if (wav_count == 0) begin
                    data_complete = 1'b1;
                    body_finished();
                end
            end
            PH_PAD: begin
                wav_phase = PH_CHUNK_HDR;
                wav_count = '0;
            end
            default: begin
                // rejected: bytes ignored until the final one
            end
        endcase

        if (is_final) begin
            res = '0;
            if (wav_phase == PH_HEADER || wav_phase == PH_BAD_HDR)
                res.status = wavp_pkg::STATUS_BAD_HDR;
            else if (wav_phase == PH_FMT_BODY || wav_phase == PH_BAD_FMT)
                res.status = wavp_pkg::STATUS_SHORT_FMT;
            else if (!(fmt_captured && data_opened))
                res.status = wavp_pkg::STATUS_MISSING;    // wins over a cut payload
            else if (!data_complete)
                res.status = wavp_pkg::STATUS_TRUNC;
            else
                res.status = wavp_pkg::STATUS_OK;
            if (res.status == wavp_pkg::STATUS_OK) begin
                res.payload_hash    = wav_hash;
                res.sample_rate     = fmt_rate;
                res.bits_per_sample = fmt_bits;
                res.channel_count   = fmt_channels;
                res.payload_length  = data_length;
            end
            file_result_q.push_back(res);
            wav_state_clear();
        end
    endfunction

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------
    function automatic void put_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(tag[8*i +: 8]);
    endfunction

    function automatic void put_le(input logic [31:0] value, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(value[8*i +: 8]);
    endfunction

    // header with a random riff size, which the parser ignores
    function automatic void put_riff();
        put_tag(wavp_pkg::TAG_RIFF);
        put_le($urandom, 4);
        put_tag(wavp_pkg::TAG_WAVE);
    endfunction

    function automatic void put_fmt(input logic [31:0] size, input logic [15:0] chans,
                                    input logic [31:0] rate, input logic [15:0] bits);
        logic [127:0] image;
        image = {$urandom, $urandom, $urandom, $urandom};
        image[16 +: 16]  = chans;
        image[32 +: 32]  = rate;
        image[112 +: 16] = bits;
        put_tag(wavp_pkg::TAG_FMT);
        put_le(size, 4);
        for (int i = 0; i < size; i++)
            file_bytes.push_back((i < 16) ? image[8*i +: 8] : 8'($urandom));
        if (size[0]) file_bytes.push_back(8'($urandom));
    endfunction

    // chunk with random body and, for an odd size, a pad byte
    function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] size);
        put_tag(tag);
        put_le(size, 4);
        for (int i = 0; i < size; i++) file_bytes.push_back(8'($urandom));
        if (size[0]) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void drop_tail(input int unsigned n);
        repeat (n) void'(file_bytes.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offer one byte, optionally after an idle burst, and wait for the transaction
    task automatic send_byte(input logic [7:0] value, input logic is_final);
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= value;
        in_if.end_of_file <= is_final;
        do @(posedge i_clk); while (!in_if.ready);
        wav_parse_step(value, is_final);
    endtask

    // send the built file, end-of-file marker on its last byte
    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        bytes_sent += file_bytes.size();
        file_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    // receiver ready: random stall bursts, plus one long hold-off on request
    initial begin : sink_ready
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_busy = 1'b1;
                out_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_busy = 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        wavp_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (file_result_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual status %0d",
                         $time, out_if.status);
                mismatch_count++;
            end else begin
                want = file_result_q.pop_front();
                check_field("status", want.status, out_if.status);
                check_field("payload_hash", want.payload_hash, out_if.payload_hash);
                check_field("sample_rate", want.sample_rate, out_if.sample_rate);
                check_field("bits_per_sample", want.bits_per_sample, out_if.bits_per_sample);
                check_field("channel_count", want.channel_count, out_if.channel_count);
                check_field("payload_length", want.payload_length, out_if.payload_length);
            end
        end
    end

    // hang detection: too long with no transaction on either channel
    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_header_checks();
        // one-byte file
        file_bytes.push_back(8'hFF);
        send_file();
        // header one byte short
        put_riff();
        drop_tail(1);
        send_file();
        // wrong outer tag, the rest of a good file is ignored
        put_tag(wavp_pkg::TAG_RIFF ^ 32'h0000_0001);
        put_le(32'd36, 4);
        put_tag(wavp_pkg::TAG_WAVE);
        put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
        put_chunk(wavp_pkg::TAG_DATA, 32'd2);
        send_file();
        // wrong form tag
        put_tag(wavp_pkg::TAG_RIFF);
        put_le(32'd0, 4);
        put_tag(wavp_pkg::TAG_WAVE ^ 32'h8000_0000);
        put_fmt(32'd16, 16'd1, 32'd8000, 16'd8);
        send_file();
        // header alone, no chunks at all
        put_riff();
        send_file();
    endtask

    task automatic test_fmt_checks();
        // fmt size one below the minimum rejects, later chunks ignored
        put_riff();
        put_fmt(32'd15, 16'd1, 32'd8000, 16'd8);
        put_chunk(wavp_pkg::TAG_DATA, 32'd4);
        send_file();
        // empty fmt
        put_riff();
        put_fmt(32'd0, 16'd0, 32'd0, 16'd0);
        put_fmt(32'd16, 16'd2, 32'd48000, 16'd24);
        put_chunk(wavp_pkg::TAG_DATA, 32'd1);
        send_file();
        // file ends inside the fmt body
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd48000, 16'd24);
        drop_tail(7);
        send_file();
    endtask

    task automatic test_complete_files();
        // plain file, odd payload with pad, both byte extremes in the payload
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
        put_tag(wavp_pkg::TAG_DATA);
        put_le(32'd5, 4);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h5A);
        file_bytes.push_back(8'h00);
        send_file();
        // all-ones fmt fields, empty data chunk keeps the offset basis
        put_riff();
        put_fmt(32'd16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_chunk(wavp_pkg::TAG_DATA, 32'd0);
        send_file();
        // all-zero fields, odd skipped chunk, extended fmt with skipped tail
        put_riff();
        put_chunk(TAG_LIST, 32'd3);
        put_fmt(32'd19, 16'd0, 32'd0, 16'd0);
        put_chunk(wavp_pkg::TAG_DATA, 32'd7);
        send_file();
        // data before fmt, later fmt and later data replace the earlier ones
        put_riff();
        put_chunk(wavp_pkg::TAG_DATA, 32'd3);
        put_fmt(32'd16, 16'd1, 32'd22050, 16'd8);
        put_chunk(TAG_JUNK, 32'd0);
        put_chunk(wavp_pkg::TAG_DATA, 32'd6);
        put_fmt(32'd18, 16'd6, 32'd96000, 16'd32);
        send_file();
    endtask

    task automatic test_missing_and_cut();
        // fmt without data
        put_riff();
        put_fmt(32'd16, 16'd1, 32'd11025, 16'd8);
        send_file();
        // data without fmt
        put_riff();
        put_chunk(wavp_pkg::TAG_DATA, 32'd4);
        send_file();
        // payload cut short
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd32000, 16'd16);
        put_chunk(wavp_pkg::TAG_DATA, 32'd10);
        drop_tail(6);
        send_file();
        // cut payload and no fmt: missing wins
        put_riff();
        put_chunk(wavp_pkg::TAG_DATA, 32'd10);
        drop_tail(3);
        send_file();
        // huge declared payload, only a few bytes follow
        put_riff();
        put_fmt(32'd16, 16'd1, 32'd16000, 16'd12);
        put_tag(wavp_pkg::TAG_DATA);
        put_le(32'hFFFF_FFFF, 4);
        put_le($urandom, 3);
        send_file();
        // partial chunk header at the end is ignored
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
        put_chunk(wavp_pkg::TAG_DATA, 32'd2);
        put_tag(wavp_pkg::TAG_FMT);
        file_bytes.push_back(8'h10);
        send_file();
        // file ends while skipping a huge chunk body
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
        put_chunk(wavp_pkg::TAG_DATA, 32'd2);
        put_tag(TAG_JUNK);
        put_le(32'hFFFF_FFF0, 4);
        put_le($urandom, 2);
        send_file();
        // file ends right before the pad byte
        put_riff();
        put_fmt(32'd16, 16'd1, 32'd8000, 16'd8);
        put_chunk(wavp_pkg::TAG_DATA, 32'd3);
        drop_tail(1);
        send_file();
        // complete first data chunk, last one cut: the cut one counts
        put_riff();
        put_fmt(32'd16, 16'd1, 32'd8000, 16'd8);
        put_chunk(wavp_pkg::TAG_DATA, 32'd2);
        put_chunk(wavp_pkg::TAG_DATA, 32'd8);
        drop_tail(2);
        send_file();
    endtask

    // receiver holds off while a stream of one-byte files fills the block
    task automatic test_backpressure();
        // nothing offered while waiting for the hold-off to start
        in_if.valid <= 1'b0;
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        @(posedge i_clk);
        wait (hold_busy);
        repeat (12) begin
            file_bytes.push_back(8'($urandom));
            send_file();
        end
        put_riff();
        put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
        put_chunk(wavp_pkg::TAG_DATA, 32'd9);
        send_file();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_files();
        int unsigned files;
        int unsigned kind;
        int unsigned pick;
        int unsigned spot;
        files = 0;
        while (files < RANDOM_FILES) begin
            // quiet tail: no idling on either side
            if (files >= RANDOM_FILES - QUIET_FILES) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                // noise
                repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
            end else begin
                put_riff();
                if ($urandom_range(0, 3) != 0)
                    put_fmt($urandom_range(16, 19), 16'($urandom), $urandom, 16'($urandom));
                repeat ($urandom_range(0, 2)) begin
                    pick = $urandom_range(0, 7);
                    case (pick) inside
                        0, 1: put_fmt($urandom_range(16, 18), 16'($urandom), $urandom,
                                      16'($urandom));
                        2, 3: put_chunk(wavp_pkg::TAG_DATA, $urandom_range(0, 16));
                        4:    put_chunk($urandom, $urandom_range(0, 7));
                        5:    put_chunk(wavp_pkg::TAG_DATA ^ (32'h1 << $urandom_range(0, 31)),
                                        $urandom_range(0, 5));
                        6:    put_chunk(wavp_pkg::TAG_FMT ^ (32'h1 << $urandom_range(0, 31)),
                                        $urandom_range(0, 5));
                        default: put_fmt($urandom_range(0, 15), 16'($urandom), $urandom,
                                         16'($urandom));
                    endcase
                end
                if ($urandom_range(0, 3) != 0)
                    put_chunk(wavp_pkg::TAG_DATA, $urandom_range(0, 16));
                // broken header: one flipped bit in a tag
                if (kind == 1) begin
                    spot = $urandom_range(0, 7);
                    if (spot > 3) spot += 4;
                    file_bytes[spot] = file_bytes[spot] ^ (8'h1 << $urandom_range(0, 7));
                end
                if ($urandom_range(0, 3) == 0)
                    drop_tail($urandom_range(0, file_bytes.size() - 1));
            end
            send_file();
            files++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = 8'h00;
        in_if.end_of_file  = 1'b0;
        src_idle_en        = 1'b1;
        snk_idle_en        = 1'b1;
        hold_req           = 1'b0;
        hold_busy          = 1'b0;
        mismatch_count     = 0;
        bytes_sent         = 0;
        wav_state_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_checks();
        test_fmt_checks();
        test_complete_files();
        test_missing_and_cut();
        test_backpressure();
        test_random_files();

        in_if.valid <= 1'b0;
        while (file_result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
